// File: rtl/bilinear_texture_sampler_unit_assert.svh
// Assertion macros used by the sampler's filter module.
// Each macro checks on the rising edge of clock and is switched off while reset is high.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bilinear sampler check failed");

// The consequent must hold after the antecedent, delayed by the dly argument.
`define BTS_ASSERT_LATER(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("bilinear sampler latency check failed");

`endif

// File: rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Types and constants shared by the bilinear texture sampler modules.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COORD_W    = 24;
   localparam int SIZE_W     = 9;
   localparam int IDX_W      = 8;
   localparam int FRAC_W     = 16;
   localparam int TEXEL_W    = 32;
   localparam int COLOUR_W   = 16;
   localparam int ADDR_W     = 2 * IDX_W;

   // 255 * 255, the scale of a premultiplied channel.
   localparam longint DEN      = 65025;
   // floor(2^32 / 65025), the reciprocal used for the final division.
   localparam longint RECIP    = 66051;
   // Rounding offset, half of DEN shifted up by the 16 weight bits.
   localparam longint HALF_DEN = 65025 * 32768;

   typedef enum logic [1:0] {
      TILE_REPEAT,
      TILE_BOUNCE,
      TILE_CLAMP,
      TILE_BORDER
   } tiling_type;

   typedef enum logic {
      CMD_WRITE,
      CMD_SAMPLE
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_TEX_WIDTH,
      CSR_TEX_HEIGHT,
      CSR_H_TILING,
      CSR_V_TILING
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0]  c1;
      logic [IDX_W-1:0]  c2;
      logic [FRAC_W-1:0] frac;
      logic              in_range;
   } axis_map_type;

   typedef struct packed {
      logic              valid;
      logic              border;
      logic [FRAC_W-1:0] frac_x;
      logic [FRAC_W-1:0] frac_y;
   } sample_ctrl_type;

   typedef struct packed {
      logic                valid;
      logic                border;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } result_type;

endpackage

// File: rtl/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bts_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bts_axis_map.sv
// ----------------------------------------------------------------------------
// bts_axis_map
// Three-stage mapping of one coordinate to two texel indices and a blend
// fraction under the axis tiling mode.
// ----------------------------------------------------------------------------
module bts_axis_map (
   input  logic                                    clock,
   input  logic signed [bts_pkg::COORD_W-1:0]      coord,
   input  logic        [bts_pkg::SIZE_W-1:0]       size,
   input  bts_pkg::tiling_type                     mode,
   output bts_pkg::axis_map_type                   map_out
);

   localparam int OPER_W = bts_pkg::FRAC_W + 1;
   localparam int PROD_W = OPER_W + bts_pkg::SIZE_W;

   logic [OPER_W-1:0]          oper_in, oper_ff;
   logic [bts_pkg::SIZE_W-1:0] scale_in, scale_ff, scale2_ff;
   logic [bts_pkg::SIZE_W-1:0] size_ff, size2_ff;
   bts_pkg::tiling_type        mode_ff, mode2_ff;
   logic                       neg_in, neg_ff, neg2_ff;
   logic                       over_in, over_ff, over2_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic [OPER_W-1:0]          fold_pos;
   logic signed [PROD_W:0]     wrap_t;
   logic [bts_pkg::IDX_W-1:0]  last_idx, wrap_c1, prod_c1;
   bts_pkg::axis_map_type      map_in, map_ff;

   assign fold_pos = coord[OPER_W-1:0];
   assign neg_in   = coord[bts_pkg::COORD_W-1];
   assign over_in  = coord > $signed(bts_pkg::COORD_W'(1 << bts_pkg::FRAC_W));

   // Repeat only needs the fractional part: whole periods drop out of the modulo.
   always_comb begin
      oper_in  = coord[OPER_W-1:0];
      scale_in = size - bts_pkg::SIZE_W'(1);
      case (mode)
         bts_pkg::TILE_REPEAT: begin
            oper_in  = {1'b0, coord[bts_pkg::FRAC_W-1:0]};
            scale_in = size;
         end
         bts_pkg::TILE_BOUNCE: begin
            if (fold_pos > OPER_W'(1 << bts_pkg::FRAC_W)) begin
               oper_in = OPER_W'((OPER_W+1)'(1 << OPER_W) - {1'b0, fold_pos});
            end else begin
               oper_in = fold_pos;
            end
         end
         default: begin
            oper_in = coord[OPER_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      oper_ff   <= oper_in;
      scale_ff  <= scale_in;
      size_ff   <= size;
      mode_ff   <= mode;
      neg_ff    <= neg_in;
      over_ff   <= over_in;
      prod_ff   <= PROD_W'(oper_ff * scale_ff);
      scale2_ff <= scale_ff;
      size2_ff  <= size_ff;
      mode2_ff  <= mode_ff;
      neg2_ff   <= neg_ff;
      over2_ff  <= over_ff;
      map_ff    <= map_in;
   end

   assign last_idx = bts_pkg::IDX_W'(size2_ff - bts_pkg::SIZE_W'(1));
   assign prod_c1  = prod_ff[bts_pkg::FRAC_W +: bts_pkg::IDX_W];
   assign wrap_c1  = wrap_t[bts_pkg::FRAC_W +: bts_pkg::IDX_W];

   // Texel centres sit half a texel in; a negative result wraps by one period.
   always_comb begin
      wrap_t = $signed({1'b0, prod_ff}) - $signed((PROD_W+1)'(1 << (bts_pkg::FRAC_W - 1)));
      if (wrap_t < 0) begin
         wrap_t = wrap_t + $signed((PROD_W+1)'({size2_ff, {bts_pkg::FRAC_W{1'b0}}}));
      end
   end

   always_comb begin
      map_in.c1       = prod_c1;
      map_in.c2       = prod_c1;
      map_in.frac     = prod_ff[bts_pkg::FRAC_W-1:0];
      map_in.in_range = 1'b1;
      case (mode2_ff)
         bts_pkg::TILE_REPEAT: begin
            map_in.c1   = wrap_c1;
            map_in.frac = wrap_t[bts_pkg::FRAC_W-1:0];
            if (({1'b0, wrap_c1} + bts_pkg::SIZE_W'(1)) == size2_ff) begin
               map_in.c2 = '0;
            end else begin
               map_in.c2 = wrap_c1 + bts_pkg::IDX_W'(1);
            end
         end
         bts_pkg::TILE_BOUNCE: begin
            if (prod_ff >= PROD_W'({scale2_ff, {bts_pkg::FRAC_W{1'b0}}})) begin
               map_in.c1   = last_idx;
               map_in.c2   = last_idx;
               map_in.frac = '0;
            end else begin
               map_in.c2 = prod_c1 + bts_pkg::IDX_W'(1);
            end
         end
         default: begin
            if (neg2_ff || over2_ff) begin
               map_in.c1       = neg2_ff ? '0 : last_idx;
               map_in.c2       = neg2_ff ? '0 : last_idx;
               map_in.frac     = '0;
               map_in.in_range = (mode2_ff == bts_pkg::TILE_CLAMP);
            end else if (prod_c1 < last_idx) begin
               map_in.c2 = prod_c1 + bts_pkg::IDX_W'(1);
            end
         end
      endcase
   end

   assign map_out = map_ff;

endmodule

// File: rtl/bts_filter.sv
// ----------------------------------------------------------------------------
// bts_filter
// Six-stage bilinear blend of four premultiplied texels, with rounding,
// division by 255 squared and saturation to Q0.16.
// ----------------------------------------------------------------------------
`include "bilinear_texture_sampler_unit_assert.svh"

module bts_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  bts_pkg::sample_ctrl_type            ctrl_in,
   input  logic [bts_pkg::TEXEL_W-1:0]         texel [4],
   output bts_pkg::result_type                 result
);

   localparam int PM_W   = 16;
   localparam int WT_W   = 2 * (bts_pkg::FRAC_W + 1) - 1;
   localparam int PR_W   = PM_W + WT_W;
   localparam int SUM_W  = PR_W + 2;
   localparam int Q_W    = SUM_W - bts_pkg::FRAC_W;
   localparam int RC_W   = 17;
   localparam int R0_W   = Q_W + RC_W - 32;
   localparam int DEN_W  = 16;
   localparam int PD_W   = R0_W + DEN_W;

   logic [bts_pkg::FRAC_W:0] gx, gy, fx, fy;
   logic [PM_W-1:0]          pm_ff  [4][3];
   logic [WT_W-1:0]          wt_ff  [4];
   logic [PR_W-1:0]          pr_ff  [4][3];
   logic [SUM_W-1:0]         sum    [3];
   logic [Q_W-1:0]           q3_ff  [3];
   logic [Q_W-1:0]           q4_ff  [3];
   logic [Q_W-1:0]           q5_ff  [3];
   logic [R0_W-1:0]          r0_ff  [3];
   logic [R0_W-1:0]          r05_ff [3];
   logic [PD_W-1:0]          pd_ff  [3];
   logic [PD_W-1:0]          rem    [3];
   logic [R0_W-1:0]          rnd    [3];
   logic [bts_pkg::COLOUR_W-1:0] sat [3];
   logic [4:0]               v_ff, b_ff;
   bts_pkg::result_type      res_in, res_ff;
   logic                     black_ok, rem_ok;

   assign fx = {1'b0, ctrl_in.frac_x};
   assign fy = {1'b0, ctrl_in.frac_y};
   assign gx = (bts_pkg::FRAC_W+1)'(1 << bts_pkg::FRAC_W) - fx;
   assign gy = (bts_pkg::FRAC_W+1)'(1 << bts_pkg::FRAC_W) - fy;

   // Texel order: (c1x,c1y), (c2x,c1y), (c1x,c2y), (c2x,c2y).
   always_ff @(posedge clock) begin
      wt_ff[0] <= WT_W'(gx * gy);
      wt_ff[1] <= WT_W'(fx * gy);
      wt_ff[2] <= WT_W'(gx * fy);
      wt_ff[3] <= WT_W'(fx * fy);
      for (int k = 0; k < 4; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            pm_ff[k][ch] <= PM_W'(texel[k][8*ch +: 8] * texel[k][31:24]);
            pr_ff[k][ch] <= PR_W'(pm_ff[k][ch] * wt_ff[k]);
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         q3_ff[ch]  <= sum[ch][SUM_W-1:bts_pkg::FRAC_W];
         r0_ff[ch]  <= R0_W'((Q_W+RC_W)'(q3_ff[ch] * RC_W'(bts_pkg::RECIP)) >> 32);
         q4_ff[ch]  <= q3_ff[ch];
         pd_ff[ch]  <= PD_W'(r0_ff[ch] * DEN_W'(bts_pkg::DEN));
         r05_ff[ch] <= r0_ff[ch];
         q5_ff[ch]  <= q4_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         res_ff.valid <= 1'b0;
      end else begin
         v_ff   <= {v_ff[3:0], ctrl_in.valid};
         res_ff <= res_in;
      end
      b_ff <= {b_ff[3:0], ctrl_in.border};
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = SUM_W'(pr_ff[0][ch]) + SUM_W'(pr_ff[1][ch]) + SUM_W'(pr_ff[2][ch])
                 + SUM_W'(pr_ff[3][ch]) + SUM_W'(bts_pkg::HALF_DEN);
      end
   end

   // The reciprocal estimate is low by at most one, so one correction step suffices.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         rem[ch] = PD_W'(q5_ff[ch]) - pd_ff[ch];
         rnd[ch] = (rem[ch] >= PD_W'(bts_pkg::DEN)) ? r05_ff[ch] + R0_W'(1) : r05_ff[ch];
         sat[ch] = (rnd[ch] > R0_W'(16'hFFFF)) ? 16'hFFFF : rnd[ch][bts_pkg::COLOUR_W-1:0];
      end
   end

   always_comb begin
      res_in.valid  = v_ff[4];
      res_in.border = b_ff[4];
      res_in.red    = b_ff[4] ? '0 : sat[0];
      res_in.green  = b_ff[4] ? '0 : sat[1];
      res_in.blue   = b_ff[4] ? '0 : sat[2];
   end

   assign result = res_ff;

   assign black_ok = (res_ff.red == '0) && (res_ff.green == '0) && (res_ff.blue == '0);
   assign rem_ok   = (rem[0] < PD_W'(2 * bts_pkg::DEN)) && (rem[1] < PD_W'(2 * bts_pkg::DEN))
                  && (rem[2] < PD_W'(2 * bts_pkg::DEN));

   `BTS_ASSERT_LATER(a_filter_latency, ctrl_in.valid, 6, res_ff.valid)
   `BTS_ASSERT_HOLDS(a_border_black, res_ff.valid && res_ff.border, black_ok)
   `BTS_ASSERT_HOLDS(a_quotient_fix, v_ff[4] && !b_ff[4], rem_ok)

endmodule

// File: rtl/bilinear_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// RGBA8 texel store with a pipelined bilinear, alpha-premultiplied sampler.
//
//   Channel   Handshake            Payload
//   request   start / busy         req_cmd, req_coord_u/v, req_texel_*, req_in_*
//   response  rsp_valid strobe     rsp_out_red/green/blue, rsp_is_border
//   csr       csr_valid/csr_ready  csr_index, csr_wdata
//
// One item is accepted every cycle while busy is low; busy is a registered
// copy of reset. A sample passes the axis maps, the store read and the
// filter. A texel write lands in the store from the end of the delay line, at
// the same stage where samples read it, so items always see the writes before
// them. The pipeline never stalls; reset clears only the valid bits.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_cmd,
   input  logic signed [bts_pkg::COORD_W-1:0]  req_coord_u,
   input  logic signed [bts_pkg::COORD_W-1:0]  req_coord_v,
   input  logic [bts_pkg::IDX_W-1:0]           req_texel_col,
   input  logic [bts_pkg::IDX_W-1:0]           req_texel_row,
   input  logic [7:0]                          req_in_red,
   input  logic [7:0]                          req_in_green,
   input  logic [7:0]                          req_in_blue,
   input  logic [7:0]                          req_in_alpha,
   output logic                                rsp_valid,
   output logic [bts_pkg::COLOUR_W-1:0]        rsp_out_red,
   output logic [bts_pkg::COLOUR_W-1:0]        rsp_out_green,
   output logic [bts_pkg::COLOUR_W-1:0]        rsp_out_blue,
   output logic                                rsp_is_border,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [bts_pkg::SIZE_W-1:0]          csr_wdata
);

   logic [bts_pkg::SIZE_W-1:0] width_ff, height_ff, width_eff, height_eff;
   bts_pkg::tiling_type        htile_ff, vtile_ff;
   logic                       busy_ff;

   logic [3:0]                 v_ff;
   bts_pkg::cmd_type           cmd_ff [4];
   logic [bts_pkg::ADDR_W-1:0] waddr_ff [4];
   logic [bts_pkg::TEXEL_W-1:0] wdata_ff [4];
   logic signed [bts_pkg::COORD_W-1:0] u_ff, v0_ff;

   bts_pkg::axis_map_type      map_x, map_y;
   logic [bts_pkg::ADDR_W-1:0] rd_addr [4];
   logic [bts_pkg::TEXEL_W-1:0] rd_data [4];
   logic                       wr_en;
   bts_pkg::sample_ctrl_type   ctrl_ff;
   bts_pkg::result_type        result;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bts_pkg::SIZE_W'(1);
         height_ff <= bts_pkg::SIZE_W'(1);
         htile_ff  <= bts_pkg::TILE_REPEAT;
         vtile_ff  <= bts_pkg::TILE_REPEAT;
         busy_ff   <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (bts_pkg::csr_index_type'(csr_index))
               bts_pkg::CSR_TEX_WIDTH:  width_ff  <= csr_wdata;
               bts_pkg::CSR_TEX_HEIGHT: height_ff <= csr_wdata;
               bts_pkg::CSR_H_TILING:   htile_ff  <= bts_pkg::tiling_type'(csr_wdata[1:0]);
               bts_pkg::CSR_V_TILING:   vtile_ff  <= bts_pkg::tiling_type'(csr_wdata[1:0]);
               default: ;
            endcase
         end
      end
   end

   // A size of zero acts as one; sizes past the store act as the store's limit.
   always_comb begin
      width_eff  = width_ff;
      height_eff = height_ff;
      if (width_ff == '0) begin
         width_eff = bts_pkg::SIZE_W'(1);
      end else if (width_ff > bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH)) begin
         width_eff = bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH);
      end
      if (height_ff == '0) begin
         height_eff = bts_pkg::SIZE_W'(1);
      end else if (height_ff > bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT)) begin
         height_eff = bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], start && !busy};
      end
      u_ff        <= req_coord_u;
      v0_ff       <= req_coord_v;
      cmd_ff[0]   <= bts_pkg::cmd_type'(req_cmd);
      waddr_ff[0] <= {req_texel_row, req_texel_col};
      wdata_ff[0] <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
      for (int s = 1; s < 4; s++) begin
         cmd_ff[s]   <= cmd_ff[s-1];
         waddr_ff[s] <= waddr_ff[s-1];
         wdata_ff[s] <= wdata_ff[s-1];
      end
   end

   bts_axis_map u_map_x (
      .clock   (clock),
      .coord   (u_ff),
      .size    (width_eff),
      .mode    (htile_ff),
      .map_out (map_x)
   );

   bts_axis_map u_map_y (
      .clock   (clock),
      .coord   (v0_ff),
      .size    (height_eff),
      .mode    (vtile_ff),
      .map_out (map_y)
   );

   assign wr_en      = v_ff[3] && (cmd_ff[3] == bts_pkg::CMD_WRITE);
   assign rd_addr[0] = {map_y.c1, map_x.c1};
   assign rd_addr[1] = {map_y.c1, map_x.c2};
   assign rd_addr[2] = {map_y.c2, map_x.c1};
   assign rd_addr[3] = {map_y.c2, map_x.c2};

   // One copy of the store per bilinear tap, all written together.
   for (genvar k = 0; k < 4; k++) begin : g_store
      bts_ram #(
         .WIDTH (bts_pkg::TEXEL_W),
         .DEPTH (bts_pkg::MAX_WIDTH * bts_pkg::MAX_HEIGHT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (waddr_ff[3]),
         .wr_data (wdata_ff[3]),
         .rd_addr (rd_addr[k]),
         .rd_data (rd_data[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= v_ff[3] && (cmd_ff[3] == bts_pkg::CMD_SAMPLE);
      end
      ctrl_ff.border <= !(map_x.in_range && map_y.in_range);
      ctrl_ff.frac_x <= map_x.frac;
      ctrl_ff.frac_y <= map_y.frac;
   end

   bts_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (ctrl_ff),
      .texel   (rd_data),
      .result  (result)
   );

   assign rsp_valid     = result.valid;
   assign rsp_out_red   = result.red;
   assign rsp_out_green = result.green;
   assign rsp_out_blue  = result.blue;
   assign rsp_is_border = result.border;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bilinear_texture_sampler_unit. A behavioural model
// of the texel store and the bilinear filter predicts every sample result,
// which is compared field by field with the strobed response. In-range
// samples only ever read texels that have been written beforehand.
// ----------------------------------------------------------------------------
module testbench;

   localparam longint ONE   = 65536;
   localparam int     LIMIT = 2000;
   localparam int     DRAIN = 14;

   typedef struct {
      int     c1;
      int     c2;
      longint frac;
      bit     in_range;
   } axis_pick;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        border;
   } colour_result;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_cmd = 0;
   logic signed [bts_pkg::COORD_W-1:0] req_coord_u = 0;
   logic signed [bts_pkg::COORD_W-1:0] req_coord_v = 0;
   logic [bts_pkg::IDX_W-1:0] req_texel_col = 0;
   logic [bts_pkg::IDX_W-1:0] req_texel_row = 0;
   logic [7:0] req_in_red = 0;
   logic [7:0] req_in_green = 0;
   logic [7:0] req_in_blue = 0;
   logic [7:0] req_in_alpha = 0;
   logic rsp_valid;
   logic [bts_pkg::COLOUR_W-1:0] rsp_out_red;
   logic [bts_pkg::COLOUR_W-1:0] rsp_out_green;
   logic [bts_pkg::COLOUR_W-1:0] rsp_out_blue;
   logic rsp_is_border;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = 0;
   logic [bts_pkg::SIZE_W-1:0] csr_wdata = 0;

   logic [31:0]         texels [0:65535];
   bit                  texel_written [0:65535];
   logic [8:0]          width_reg, height_reg;
   bts_pkg::tiling_type h_mode, v_mode;
   colour_result        pending_colours[$];
   int                  errors = 0;
   int                  quiet_cycles = 0;
   bit                  gaps_on = 1;

   bilinear_texture_sampler_unit dut (.*);

   always #5 clock = ~clock;

   function automatic longint eff_size(logic [8:0] v, longint maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic axis_pick map_coord(longint x, longint n, bts_pkg::tiling_type mode);
      axis_pick p;
      longint t, r;
      p.in_range = 1;
      p.frac = 0;
      if (mode == bts_pkg::TILE_REPEAT) begin
         t = (x * n - ONE / 2) % (n * ONE);
         if (t < 0) t += n * ONE;
         p.c1 = int'(t / ONE);
         p.c2 = (p.c1 + 1) % int'(n);
         p.frac = t & 16'hFFFF;
      end else if (mode == bts_pkg::TILE_BOUNCE) begin
         r = x % (2 * ONE);
         if (r < 0) r += 2 * ONE;
         if (r > ONE) r = 2 * ONE - r;
         t = r * (n - 1);
         if (t >= (n - 1) * ONE) begin
            p.c1 = int'(n - 1);
            p.c2 = int'(n - 1);
         end else begin
            p.c1 = int'(t / ONE);
            p.c2 = (p.c1 + 1) % int'(n);
            p.frac = t & 16'hFFFF;
         end
      end else if (x < 0) begin
         p.c1 = 0;
         p.c2 = 0;
         p.in_range = (mode == bts_pkg::TILE_CLAMP);
      end else if (x > ONE) begin
         p.c1 = int'(n - 1);
         p.c2 = int'(n - 1);
         p.in_range = (mode == bts_pkg::TILE_CLAMP);
      end else begin
         t = x * (n - 1);
         p.c1 = int'(t / ONE);
         if (p.c1 > n - 1) p.c1 = int'(n - 1);
         p.c2 = (p.c1 < n - 1) ? p.c1 + 1 : p.c1;
         p.frac = t & 16'hFFFF;
      end
      return p;
   endfunction

   function automatic colour_result filter_sample(longint u, longint v);
      colour_result res;
      axis_pick mx, my;
      longint unsigned fx, fy, gx, gy, num, q;
      longint unsigned den;
      logic [31:0] corner [4];
      longint unsigned w [4];
      mx = map_coord(u, eff_size(width_reg, bts_pkg::MAX_WIDTH), h_mode);
      my = map_coord(v, eff_size(height_reg, bts_pkg::MAX_HEIGHT), v_mode);
      res = '{16'd0, 16'd0, 16'd0, 1'b1};
      if (!mx.in_range || !my.in_range) return res;
      res.border = 0;
      corner[0] = texels[my.c1 * bts_pkg::MAX_WIDTH + mx.c1];
      corner[1] = texels[my.c1 * bts_pkg::MAX_WIDTH + mx.c2];
      corner[2] = texels[my.c2 * bts_pkg::MAX_WIDTH + mx.c1];
      corner[3] = texels[my.c2 * bts_pkg::MAX_WIDTH + mx.c2];
      fx = mx.frac; fy = my.frac; gx = ONE - fx; gy = ONE - fy;
      w[0] = gx * gy; w[1] = fx * gy; w[2] = gx * fy; w[3] = fx * fy;
      den = 64'd65025 << 16;
      for (int ch = 0; ch < 3; ch++) begin
         num = 0;
         for (int k = 0; k < 4; k++)
            num += longint'(corner[k][ch*8 +: 8]) * longint'(corner[k][31:24]) * w[k];
         q = (num + den / 2) / den;
         if (q > 65535) q = 65535;
         if (ch == 0) res.red = 16'(q);
         else if (ch == 1) res.green = 16'(q);
         else res.blue = 16'(q);
      end
      return res;
   endfunction

   // Caller is at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(bts_pkg::cmd_type cmd, logic [23:0] u, logic [23:0] v,
                            logic [7:0] col, logic [7:0] row, logic [31:0] rgba);
      if (gaps_on) begin
         while ($urandom_range(0, 99) < 20) begin
            start = 0;
            @(negedge clock);
         end
      end
      start = 1;
      req_cmd = cmd;
      req_coord_u = u;
      req_coord_v = v;
      req_texel_col = col;
      req_texel_row = row;
      {req_in_alpha, req_in_blue, req_in_green, req_in_red} = rgba;
      do @(posedge clock); while (busy);
      if (cmd == bts_pkg::CMD_WRITE) begin
         texels[{row, col}] = rgba;
         texel_written[{row, col}] = 1;
      end else begin
         pending_colours.push_back(filter_sample(longint'($signed(u)), longint'($signed(v))));
      end
      @(negedge clock);
   endtask

   // When the sample is in range, writes any corner texel that has not yet been written, then samples.
   task automatic sample_at(logic [23:0] u, logic [23:0] v);
      axis_pick mx, my;
      int cols [2], rows [2];
      mx = map_coord(longint'($signed(u)), eff_size(width_reg, bts_pkg::MAX_WIDTH), h_mode);
      my = map_coord(longint'($signed(v)), eff_size(height_reg, bts_pkg::MAX_HEIGHT), v_mode);
      cols = '{mx.c1, mx.c2};
      rows = '{my.c1, my.c2};
      if (mx.in_range && my.in_range)
         foreach (rows[i]) foreach (cols[j])
            if (!texel_written[rows[i] * bts_pkg::MAX_WIDTH + cols[j]])
               send_item(bts_pkg::CMD_WRITE, $urandom, $urandom, 8'(cols[j]), 8'(rows[i]),
                         $urandom);
      send_item(bts_pkg::CMD_SAMPLE, u, v, $urandom, $urandom, $urandom);
   endtask

   task automatic settle();
      start = 0;
      while (pending_colours.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_csr(bts_pkg::csr_index_type idx, logic [8:0] data);
      settle();
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bts_pkg::CSR_TEX_WIDTH:  width_reg = data;
         bts_pkg::CSR_TEX_HEIGHT: height_reg = data;
         bts_pkg::CSR_H_TILING:   h_mode = bts_pkg::tiling_type'(data[1:0]);
         bts_pkg::CSR_V_TILING:   v_mode = bts_pkg::tiling_type'(data[1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic configure(logic [8:0] w, logic [8:0] h, bts_pkg::tiling_type hm,
                            bts_pkg::tiling_type vm);
      write_csr(bts_pkg::CSR_TEX_WIDTH, w);
      write_csr(bts_pkg::CSR_TEX_HEIGHT, h);
      write_csr(bts_pkg::CSR_H_TILING, 9'(hm));
      write_csr(bts_pkg::CSR_V_TILING, 9'(vm));
   endtask

   function automatic logic [23:0] pick_coord();
      logic [23:0] specials [8] = '{24'h000000, 24'h010000, 24'hFFFFFF, 24'h010001,
                                    24'h7FFFFF, 24'h800000, 24'h008000, 24'h00FFFF};
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 24'($signed($urandom_range(0, 5 * ONE)) - 2 * ONE);
         2: return $urandom_range(0, ONE);
         default: return specials[$urandom_range(0, 7)];
      endcase
   endfunction

   task automatic test_reset_defaults();
      width_reg = 1; height_reg = 1;
      h_mode = bts_pkg::TILE_REPEAT; v_mode = bts_pkg::TILE_REPEAT;
      sample_at(24'h000000, 24'h000000);
      sample_at(24'h7FFFFF, 24'h800000);
   endtask

   task automatic test_tiling_extremes();
      logic [23:0] edge_coords [6] = '{24'h800000, 24'h7FFFFF, 24'hFFFFFF,
                                       24'h000000, 24'h010000, 24'h010001};
      for (int m = 0; m < 4; m++) begin
         configure(4, 3, bts_pkg::tiling_type'(m), bts_pkg::tiling_type'(3 - m));
         foreach (edge_coords[i]) sample_at(edge_coords[i], edge_coords[5 - i]);
      end
      // Full-intensity texels saturate the filter output.
      configure(1, 1, bts_pkg::TILE_CLAMP, bts_pkg::TILE_CLAMP);
      send_item(bts_pkg::CMD_WRITE, 0, 0, 0, 0, 32'hFFFFFFFF);
      sample_at(24'h000000, 24'h000000);
   endtask

   task automatic test_size_limits();
      configure(0, 511, bts_pkg::TILE_REPEAT, bts_pkg::TILE_CLAMP);
      sample_at(24'h000000, 24'h010000);
      sample_at(24'h00C000, 24'h004000);
      configure(257, 256, bts_pkg::TILE_BOUNCE, bts_pkg::TILE_REPEAT);
      sample_at(24'h7FFFFF, 24'h000000);
      sample_at(24'h012345, 24'hFEDCBA);
   endtask

   task automatic test_random_sampling();
      logic [8:0] sizes [6] = '{1, 2, 256, 0, 511, 300};
      logic [8:0] w, h;
      for (int phase = 0; phase < 10; phase++) begin
         w = (phase < 6) ? sizes[phase] : 9'($urandom_range(1, 16));
         h = (phase < 6) ? sizes[5 - phase] : 9'($urandom_range(1, 16));
         configure(w, h, bts_pkg::tiling_type'($urandom_range(0, 3)),
                   bts_pkg::tiling_type'($urandom_range(0, 3)));
         gaps_on = (phase != 3);
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_item(bts_pkg::CMD_WRITE, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            else
               sample_at(pick_coord(), pick_coord());
            // Hold the sender off once per phase until no sample result is pending.
            if (i == 10) begin
               start = 0;
               while (pending_colours.size() != 0) @(negedge clock);
            end
         end
         gaps_on = 1;
      end
   endtask

   always @(posedge clock) begin
      colour_result exp_res;
      if (!reset && rsp_valid) begin
         if (pending_colours.size() == 0) begin
            $error("unexpected result: red %0d green %0d blue %0d border %0d",
                   rsp_out_red, rsp_out_green, rsp_out_blue, rsp_is_border);
            errors++;
         end else begin
            exp_res = pending_colours.pop_front();
            if (rsp_out_red !== exp_res.red) begin
               $error("out_red expected %0d actual %0d", exp_res.red, rsp_out_red);
               errors++;
            end
            if (rsp_out_green !== exp_res.green) begin
               $error("out_green expected %0d actual %0d", exp_res.green, rsp_out_green);
               errors++;
            end
            if (rsp_out_blue !== exp_res.blue) begin
               $error("out_blue expected %0d actual %0d", exp_res.blue, rsp_out_blue);
               errors++;
            end
            if (rsp_is_border !== exp_res.border) begin
               $error("is_border expected %0d actual %0d", exp_res.border, rsp_is_border);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
         $display("bilinear_texture_sampler_unit: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_reset_defaults();
      test_tiling_extremes();
      test_size_limits();
      test_random_sampling();
      settle();
      if (errors == 0)
         $display("bilinear_texture_sampler_unit: match");
      else
         $display("bilinear_texture_sampler_unit: mismatch");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bts_axis_map.sv
rtl/bts_filter.sv
rtl/bilinear_texture_sampler_unit.sv
tb/testbench.sv
